### src/ipf_pkg.sv
// Shared types, codes and character constants for the integer printf formatter.
// This package has no dependencies. Every other file in src except ipf_checker uses it.
package ipf_pkg;

  localparam int CHUNK_BYTES     = 8;
  localparam int MAX_FIELD_WIDTH = 255;
  localparam int NUM_DIGITS      = 64;
  localparam int BCD_DIGITS      = 20;
  localparam int BITS_PER_STAGE  = 8;

  // Conversion kinds.
  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_HEXL = 3'd3;
  localparam logic [2:0] KIND_HEXU = 3'd4;
  localparam logic [2:0] KIND_BIN  = 3'd5;

  // Operand size codes.
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // ASCII characters.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] mag;
    logic        neg;
    logic        left;
    logic        plus;
    logic        zpad;
    logic        blank;
    logic        alt;
    logic [7:0]  width;
    logic [7:0]  prec;
  } item_t;

  typedef struct packed {
    item_t       it;
    logic [63:0] rem;
    logic [79:0] bcd;
  } conv_t;

  typedef struct packed {
    logic [8:0]   b1;
    logic [8:0]   b2;
    logic [8:0]   b3;
    logic [8:0]   b4;
    logic [8:0]   len;
    logic [7:0]   pre0;
    logic [7:0]   pre1;
    logic         upper;
    logic [255:0] dig;
  } layout_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = (upper ? CH_UA : CH_LA) + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

### src/ipf_decode.sv
// Input stage: operand masking, sign handling and flag resolution.
// Depends on ipf_pkg.
module ipf_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [2:0]        kind,
  input  logic [63:0]       value,
  input  logic [1:0]        operand_size,
  input  logic              left_align,
  input  logic              force_plus,
  input  logic              zero_pad,
  input  logic              blank_sign,
  input  logic              alternate_form,
  input  logic [7:0]        field_width,
  input  logic signed [8:0] min_digits,
  output logic              valid_o,
  output ipf_pkg::item_t    item_o
);

  logic [63:0]    mask;
  logic           sign;
  logic [63:0]    raw;
  ipf_pkg::item_t item_next;

  always_comb begin
    unique case (operand_size)
      ipf_pkg::SIZE_8:  begin mask = 64'hFF;        sign = value[7];  end
      ipf_pkg::SIZE_16: begin mask = 64'hFFFF;      sign = value[15]; end
      ipf_pkg::SIZE_32: begin mask = 64'hFFFF_FFFF; sign = value[31]; end
      default:          begin mask = '1;            sign = value[63]; end
    endcase
    raw = value & mask;
    item_next.kind  = (kind > ipf_pkg::KIND_BIN) ? ipf_pkg::KIND_UDEC : kind;
    item_next.neg   = (kind == ipf_pkg::KIND_SDEC) && sign;
    item_next.mag   = item_next.neg ? ((~raw + 64'd1) & mask) : raw;
    item_next.left  = left_align;
    item_next.plus  = force_plus;
    item_next.zpad  = zero_pad & ~left_align;
    item_next.blank = blank_sign & ~force_plus;
    item_next.alt   = alternate_form;
    item_next.width = field_width;
    item_next.prec  = min_digits[8] ? 8'd1 : min_digits[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= in_valid;
      item_o  <= item_next;
    end
  end

endmodule

### src/ipf_bcd_stage.sv
// One stage of the binary to BCD converter: eight shift-and-add-3 steps.
// Depends on ipf_pkg.
module ipf_bcd_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           valid_i,
  input  ipf_pkg::conv_t conv_i,
  output logic           valid_o,
  output ipf_pkg::conv_t conv_o
);

  ipf_pkg::conv_t conv_next;

  always_comb begin
    conv_next = conv_i;
    for (int s = 0; s < ipf_pkg::BITS_PER_STAGE; s++) begin
      for (int d = 0; d < ipf_pkg::BCD_DIGITS; d++) begin
        if (conv_next.bcd[4*d +: 4] >= 4'd5) begin
          conv_next.bcd[4*d +: 4] = conv_next.bcd[4*d +: 4] + 4'd3;
        end
      end
      conv_next.bcd = {conv_next.bcd[78:0], conv_next.rem[63]};
      conv_next.rem = {conv_next.rem[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= valid_i;
      conv_o  <= conv_next;
    end
  end

endmodule

### src/ipf_digits.sv
// Digit extraction, field layout and digit alignment, three register stages.
// Depends on ipf_pkg.
module ipf_digits (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             valid_i,
  input  ipf_pkg::conv_t   conv_i,
  output logic             valid_o,
  output ipf_pkg::layout_t lay_o
);

  // Digit vector, least significant digit in the low nibble.
  logic [255:0]     dig_c;
  logic [6:0]       nd_c;
  logic             vc;
  ipf_pkg::item_t   it_c;
  logic [255:0]     dig_r;
  logic [6:0]       nd_r;

  always_comb begin
    dig_c = '0;
    unique case (conv_i.it.kind)
      ipf_pkg::KIND_OCT: begin
        for (int i = 0; i < 22; i++) begin
          if (i < 21) begin
            dig_c[4*i +: 4] = {1'b0, conv_i.it.mag[3*i +: 3]};
          end else begin
            dig_c[4*i +: 4] = {3'd0, conv_i.it.mag[63]};
          end
        end
      end
      ipf_pkg::KIND_HEXL, ipf_pkg::KIND_HEXU: begin
        dig_c[63:0] = conv_i.it.mag;
      end
      ipf_pkg::KIND_BIN: begin
        for (int i = 0; i < ipf_pkg::NUM_DIGITS; i++) begin
          dig_c[4*i +: 4] = {3'd0, conv_i.it.mag[i]};
        end
      end
      default: begin
        dig_c[79:0] = conv_i.bcd;
      end
    endcase
    nd_c = '0;
    for (int i = 0; i < ipf_pkg::NUM_DIGITS; i++) begin
      if (dig_c[4*i +: 4] != 4'd0) begin
        nd_c = 7'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc    <= valid_i;
      it_c  <= conv_i.it;
      dig_r <= dig_c;
      nd_r  <= nd_c;
    end
  end

  // Layout of the field: spaces, prefix, zeros, digits, spaces.
  logic [6:0]       nde;
  logic [7:0]       post0;
  logic [1:0]       pre_n;
  logic [7:0]       pre0;
  logic [7:0]       pre1;
  logic [8:0]       body;
  logic [8:0]       pad;
  logic             is_zero;
  ipf_pkg::layout_t lay_d;
  logic             vd;
  logic [6:0]       nd_d;

  always_comb begin
    is_zero = (it_c.mag == 64'd0);
    nde     = is_zero ? ((it_c.prec != 8'd0) ? 7'd1 : 7'd0) : nd_r;
    post0   = (it_c.prec > {1'b0, nde}) ? (it_c.prec - {1'b0, nde}) : 8'd0;
    pre_n   = 2'd0;
    pre0    = ipf_pkg::CH_ZERO;
    pre1    = ipf_pkg::CH_LX;
    if (it_c.kind == ipf_pkg::KIND_SDEC) begin
      pre_n = (it_c.neg || it_c.plus || it_c.blank) ? 2'd1 : 2'd0;
      pre0  = it_c.neg ? ipf_pkg::CH_MINUS :
              (it_c.plus ? ipf_pkg::CH_PLUS : ipf_pkg::CH_SPACE);
    end else if (it_c.alt) begin
      if (it_c.kind == ipf_pkg::KIND_OCT) begin
        if ((!is_zero && post0 == 8'd0) || (is_zero && it_c.prec == 8'd0)) begin
          pre_n = 2'd1;
        end
      end else if (!is_zero && (it_c.kind == ipf_pkg::KIND_HEXL ||
                   it_c.kind == ipf_pkg::KIND_HEXU || it_c.kind == ipf_pkg::KIND_BIN)) begin
        pre_n = 2'd2;
        pre1  = (it_c.kind == ipf_pkg::KIND_HEXL) ? ipf_pkg::CH_LX :
                ((it_c.kind == ipf_pkg::KIND_HEXU) ? ipf_pkg::CH_UX : ipf_pkg::CH_BANG);
      end
    end
    body  = 9'(pre_n) + 9'(post0) + 9'(nde);
    pad   = ({1'b0, it_c.width} > body) ? ({1'b0, it_c.width} - body) : 9'd0;
    lay_d.b1    = (!it_c.left && !it_c.zpad) ? pad : 9'd0;
    lay_d.b2    = lay_d.b1 + 9'(pre_n);
    lay_d.b3    = lay_d.b2 + 9'(post0) + (it_c.zpad ? pad : 9'd0);
    lay_d.b4    = lay_d.b3 + 9'(nde);
    lay_d.len   = lay_d.b4 + (it_c.left ? pad : 9'd0);
    lay_d.pre0  = pre0;
    lay_d.pre1  = pre1;
    lay_d.upper = (it_c.kind == ipf_pkg::KIND_HEXU);
    lay_d.dig   = dig_r;
  end

  ipf_pkg::layout_t lay_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd    <= vc;
      lay_r <= lay_d;
      nd_d  <= nde;
    end
  end

  // Move the most significant digit to the top nibble.
  ipf_pkg::layout_t lay_e;
  logic [6:0]       sh;

  always_comb begin
    sh        = 7'(7'd64 - nd_d);
    lay_e     = lay_r;
    lay_e.dig = lay_r.dig << {sh, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= vd;
      lay_o   <= lay_e;
    end
  end

endmodule

### src/ipf_chunker.sv
// Chunk sequencer: walks one laid-out field and emits up to eight characters a beat.
// Depends on ipf_pkg.
module ipf_chunker (
  input  logic             clk,
  input  logic             rst,
  input  logic             pend_valid,
  input  ipf_pkg::layout_t pend,
  output logic             load,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      text_bytes,
  output logic [3:0]       byte_count,
  output logic             last_chunk,
  output logic [8:0]       field_length
);

  logic             busy;
  logic [9:0]       pos;
  ipf_pkg::layout_t cur;

  logic [63:0] word;
  logic [3:0]  k;
  logic [9:0]  j0;
  logic [9:0]  p;
  logic [2:0]  idx;
  logic [31:0] win;
  logic [9:0]  rem;
  logic [3:0]  n;
  logic        last;
  logic        emit;

  always_comb begin
    word = '0;
    k    = '0;
    win  = cur.dig[255:224];
    j0   = (pos < {1'b0, cur.b3}) ? ({1'b0, cur.b3} - pos) : 10'd0;
    p    = pos;
    idx  = '0;
    for (int j = 0; j < ipf_pkg::CHUNK_BYTES; j++) begin
      p   = pos + 10'(j);
      idx = 3'(10'(j) - j0);
      if (p >= {1'b0, cur.len}) begin
        word[8*j +: 8] = 8'd0;
      end else if (p < {1'b0, cur.b1}) begin
        word[8*j +: 8] = ipf_pkg::CH_SPACE;
      end else if (p < {1'b0, cur.b2}) begin
        word[8*j +: 8] = (p == {1'b0, cur.b1}) ? cur.pre0 : cur.pre1;
      end else if (p < {1'b0, cur.b3}) begin
        word[8*j +: 8] = ipf_pkg::CH_ZERO;
      end else if (p < {1'b0, cur.b4}) begin
        word[8*j +: 8] = ipf_pkg::digit_char(win[(7 - idx)*4 +: 4], cur.upper);
        k = k + 4'd1;
      end else begin
        word[8*j +: 8] = ipf_pkg::CH_SPACE;
      end
    end
    rem  = {1'b0, cur.len} - pos;
    last = (rem <= 10'(ipf_pkg::CHUNK_BYTES));
    n    = last ? rem[3:0] : 4'(ipf_pkg::CHUNK_BYTES);
    emit = busy && (!out_valid || !out_stall);
    load = pend_valid && (!busy || (emit && last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid    <= 1'b1;
        text_bytes   <= word;
        byte_count   <= n;
        last_chunk   <= last;
        field_length <= cur.len;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
        pos  <= '0;
        cur  <= pend;
      end else if (emit) begin
        pos     <= pos + 10'(ipf_pkg::CHUNK_BYTES);
        cur.dig <= cur.dig << {k, 2'b00};
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### src/integer_printf_formatter_top.sv
// Top level of the integer printf formatter: decode, BCD pipeline, layout, chunker.
// Depends on ipf_pkg, ipf_decode, ipf_bcd_stage, ipf_digits and ipf_chunker.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | input     | in_valid / in_stall  | kind, value, operand_size, flags,
//           |           |                      | field_width, min_digits
//   out     | output    | out_valid / out_stall| text_bytes, byte_count, last_chunk,
//           |           |                      | field_length
//
// Each input beat yields ceil(field_length / 8) output beats, and at least one
// beat for an empty field. The chunk sequencer emits one beat per cycle while
// out_stall is low, so a field occupies it for its beats; this sets the sustained rate.
// The first chunk reaches the output through one decode stage, eight BCD stages
// of eight bits each, three layout stages, the sequencer's field register and
// the output register, the first of them written at the accepting edge.
// Reset is synchronous and clears only valid bits and sequencer control.
// When the sequencer cannot take the next field the whole pipeline holds; a
// stall on the output never drops or repeats a beat.
module integer_printf_formatter_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        kind,
  input  logic [63:0]       value,
  input  logic [1:0]        operand_size,
  input  logic              left_align,
  input  logic              force_plus,
  input  logic              zero_pad,
  input  logic              blank_sign,
  input  logic              alternate_form,
  input  logic [7:0]        field_width,
  input  logic signed [8:0] min_digits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       text_bytes,
  output logic [3:0]        byte_count,
  output logic              last_chunk,
  output logic [8:0]        field_length
);

  localparam int NUM_STAGES = 64 / ipf_pkg::BITS_PER_STAGE;

  logic             adv;
  logic             load;
  logic             dec_valid;
  ipf_pkg::item_t   dec_item;
  logic             conv_valid [0:NUM_STAGES];
  ipf_pkg::conv_t   conv       [0:NUM_STAGES];
  logic             lay_valid;
  ipf_pkg::layout_t lay;

  // The pipeline moves as a whole; it only holds when a finished field is
  // waiting at its end and the sequencer is still busy with the one before.
  assign adv      = !lay_valid || load;
  assign in_stall = !adv;

  ipf_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (in_valid),
    .kind           (kind),
    .value          (value),
    .operand_size   (operand_size),
    .left_align     (left_align),
    .force_plus     (force_plus),
    .zero_pad       (zero_pad),
    .blank_sign     (blank_sign),
    .alternate_form (alternate_form),
    .field_width    (field_width),
    .min_digits     (min_digits),
    .valid_o        (dec_valid),
    .item_o         (dec_item)
  );

  // The BCD converter consumes the magnitude from its top bit down.
  assign conv_valid[0] = dec_valid;
  assign conv[0].it    = dec_item;
  assign conv[0].rem   = dec_item.mag;
  assign conv[0].bcd   = '0;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_bcd
    ipf_bcd_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .valid_i (conv_valid[g]),
      .conv_i  (conv[g]),
      .valid_o (conv_valid[g+1]),
      .conv_o  (conv[g+1])
    );
  end

  ipf_digits u_digits (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .valid_i (conv_valid[NUM_STAGES]),
    .conv_i  (conv[NUM_STAGES]),
    .valid_o (lay_valid),
    .lay_o   (lay)
  );

  ipf_chunker u_chunker (
    .clk          (clk),
    .rst          (rst),
    .pend_valid   (lay_valid),
    .pend         (lay),
    .load         (load),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .text_bytes   (text_bytes),
    .byte_count   (byte_count),
    .last_chunk   (last_chunk),
    .field_length (field_length)
  );

endmodule

### src/ipf_checker.sv
// Port-level checks for the integer printf formatter, bound to the top level.
// Depends on integer_printf_formatter_top.
module ipf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] text_bytes,
  input logic [3:0]  byte_count,
  input logic        last_chunk,
  input logic [8:0]  field_length
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(text_bytes))
    else $error("stalled output beat changed");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_chunk |-> byte_count == 4'd8)
    else $error("inner chunk is not full");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == 4'd0 |-> last_chunk && field_length == 9'd0)
    else $error("empty chunk outside an empty field");

  a_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_chunk |=>
      out_valid && field_length == $past(field_length))
    else $error("field continuation missing or length changed");

endmodule

bind integer_printf_formatter_top ipf_checker u_ipf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .text_bytes   (text_bytes),
  .byte_count   (byte_count),
  .last_chunk   (last_chunk),
  .field_length (field_length)
);

### bench/tb_integer_printf_formatter_top.sv
// Self-checking bench for the integer printf formatter: directed rows, then random beats.
// Depends on ipf_pkg and integer_printf_formatter_top; predicts chunks with its own formatter.
module tb_integer_printf_formatter_top;

  // One output beat as the bench expects it.
  typedef struct {
    logic [63:0] text;
    logic [3:0]  count;
    logic        last;
    logic [8:0]  flen;
  } chunk_t;

  // One input beat. A directed row may carry a typed-in first chunk.
  typedef struct {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [1:0]  size;
    logic [4:0]  flags;   // left, plus, zero, blank, alternate
    logic [7:0]  width;
    logic [8:0]  prec;
    logic        has_lit;
    logic [63:0] lit_text;
    logic [8:0]  lit_len;
  } fmt_req_t;

  localparam int NUM_RANDOM = 310;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [8:0] PREC_DEFAULT = 9'h1FF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic [63:0] value = '0;
  logic [1:0] operand_size = '0;
  logic left_align = 1'b0, force_plus = 1'b0, zero_pad = 1'b0;
  logic blank_sign = 1'b0, alternate_form = 1'b0;
  logic [7:0] field_width = '0;
  logic signed [8:0] min_digits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] text_bytes;
  logic [3:0] byte_count;
  logic last_chunk;
  logic [8:0] field_length;

  integer_printf_formatter_top i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  chunk_t   pending_chunks[$];
  fmt_req_t stimulus[$];
  int errors = 0;
  int fields_sent = 0;
  int chunks_seen = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  // Builds the formatted field character by character and splits it into chunks.
  task automatic format_field(input fmt_req_t r);
    logic [63:0] msk, mag, sbit, v;
    logic [7:0] digs[$];
    logic [7:0] pfx[$];
    logic [7:0] txt[$];
    logic left, plus, zpad, blank, alt, neg, upper;
    int prec, nd, post0, body, pad, fl, base, d, n;
    chunk_t c;
    left = r.flags[4]; plus = r.flags[3]; zpad = r.flags[2] & ~left;
    blank = r.flags[1] & ~plus; alt = r.flags[0];
    prec = r.prec[8] ? 1 : int'(r.prec);
    case (r.size)
      ipf_pkg::SIZE_8:  msk = 64'hFF;
      ipf_pkg::SIZE_16: msk = 64'hFFFF;
      ipf_pkg::SIZE_32: msk = 64'hFFFF_FFFF;
      default: msk = '1;
    endcase
    mag = r.value & msk;
    neg = 1'b0;
    if (r.kind == ipf_pkg::KIND_SDEC) begin
      sbit = (msk >> 1) + 64'd1;
      if ((mag & sbit) != 0) begin
        neg = 1'b1;
        mag = (~mag + 64'd1) & msk;
      end
    end
    case (r.kind)
      ipf_pkg::KIND_OCT: base = 8;
      ipf_pkg::KIND_HEXL, ipf_pkg::KIND_HEXU: base = 16;
      ipf_pkg::KIND_BIN: base = 2;
      default: base = 10;
    endcase
    upper = (r.kind == ipf_pkg::KIND_HEXU);
    v = mag;
    while (v != 0) begin
      d = int'(v % base);
      digs.push_front(d < 10 ? ipf_pkg::CH_ZERO + 8'(d) :
                      (upper ? ipf_pkg::CH_UA : ipf_pkg::CH_LA) + 8'(d - 10));
      v = v / base;
    end
    if (mag == 0 && prec != 0) digs.push_front(ipf_pkg::CH_ZERO);
    nd = digs.size();
    post0 = (prec > nd) ? prec - nd : 0;
    if (r.kind == ipf_pkg::KIND_SDEC) begin
      if (neg) pfx.push_back(ipf_pkg::CH_MINUS);
      else if (plus) pfx.push_back(ipf_pkg::CH_PLUS);
      else if (blank) pfx.push_back(ipf_pkg::CH_SPACE);
    end else if (alt) begin
      if (r.kind == ipf_pkg::KIND_OCT) begin
        if ((mag != 0 && post0 == 0) || (mag == 0 && prec == 0))
          pfx.push_back(ipf_pkg::CH_ZERO);
      end else if (mag != 0 && r.kind inside {ipf_pkg::KIND_HEXL, ipf_pkg::KIND_HEXU,
                                               ipf_pkg::KIND_BIN}) begin
        pfx.push_back(ipf_pkg::CH_ZERO);
        pfx.push_back(r.kind == ipf_pkg::KIND_HEXL ? ipf_pkg::CH_LX :
                      (r.kind == ipf_pkg::KIND_HEXU ? ipf_pkg::CH_UX : ipf_pkg::CH_BANG));
      end
    end
    body = pfx.size() + post0 + nd;
    pad = (int'(r.width) > body) ? int'(r.width) - body : 0;
    fl = body + pad;
    if (!left && !zpad) repeat (pad) txt.push_back(ipf_pkg::CH_SPACE);
    foreach (pfx[i]) txt.push_back(pfx[i]);
    if (!left && zpad) repeat (pad) txt.push_back(ipf_pkg::CH_ZERO);
    repeat (post0) txt.push_back(ipf_pkg::CH_ZERO);
    foreach (digs[i]) txt.push_back(digs[i]);
    if (left) repeat (pad) txt.push_back(ipf_pkg::CH_SPACE);
    if (fl == 0) begin
      c.text = '0; c.count = '0; c.last = 1'b1; c.flen = '0;
      pending_chunks.push_back(c);
    end
    for (int p = 0; p < fl; p += ipf_pkg::CHUNK_BYTES) begin
      n = (fl - p > ipf_pkg::CHUNK_BYTES) ? ipf_pkg::CHUNK_BYTES : fl - p;
      c.text = '0;
      for (int i = 0; i < n; i++) c.text[8*i +: 8] = txt[p + i];
      c.count = 4'(n);
      c.last = (p + n >= fl);
      c.flen = 9'(fl);
      pending_chunks.push_back(c);
    end
    // A typed-in row also pins the first chunk and the length.
    if (r.has_lit) begin
      c = pending_chunks[pending_chunks.size() - ((fl + 7) / 8 == 0 ? 1 : (fl + 7) / 8)];
      if (c.text !== r.lit_text || c.flen !== r.lit_len) begin
        $error("table row disagrees with predictor: text %h/%h len %0d/%0d",
               r.lit_text, c.text, r.lit_len, c.flen);
        errors++;
      end
    end
  endtask

  function automatic fmt_req_t row(logic [2:0] k, logic [63:0] v, logic [1:0] s,
                                   logic [4:0] f, logic [7:0] w, logic [8:0] p,
                                   logic lit = 1'b0, logic [63:0] lt = '0,
                                   logic [8:0] ll = '0);
    fmt_req_t r;
    r.kind = k; r.value = v; r.size = s; r.flags = f; r.width = w; r.prec = p;
    r.has_lit = lit; r.lit_text = lt; r.lit_len = ll;
    return r;
  endfunction

  // Random beat: small widths mostly, occasionally a wide field of 128 to 255.
  function automatic fmt_req_t random_req();
    fmt_req_t r;
    r.kind = 3'($urandom_range(0, 7));
    r.value = {$urandom(), $urandom()};
    if ($urandom_range(0, 5) == 0) r.value = 64'($urandom_range(0, 3));
    r.size = 2'($urandom_range(0, 3));
    r.flags = 5'($urandom());
    case ($urandom_range(0, 9))
      0: r.width = 8'($urandom_range(128, 255));
      1, 2: r.width = 8'($urandom_range(0, 40));
      default: r.width = 8'($urandom_range(0, 16));
    endcase
    case ($urandom_range(0, 7))
      0: r.prec = 9'($urandom_range(256, 511));
      1: r.prec = 9'($urandom_range(0, 255));
      2, 3: r.prec = 9'($urandom_range(0, 24));
      default: r.prec = PREC_DEFAULT;
    endcase
    r.has_lit = 1'b0; r.lit_text = '0; r.lit_len = '0;
    return r;
  endfunction

  initial begin
    // Directed rows: extremes, every kind, flag conflicts and the zero cases.
    stimulus.push_back(row(ipf_pkg::KIND_SDEC, 64'd0, ipf_pkg::SIZE_8, 5'b00000, 8'd0, 9'd0,
                           1'b1, 64'd0, 9'd0));
    stimulus.push_back(row(ipf_pkg::KIND_SDEC, 64'd0, ipf_pkg::SIZE_8, 5'b00000, 8'd0,
                           PREC_DEFAULT, 1'b1, 64'h30, 9'd1));
    stimulus.push_back(row(ipf_pkg::KIND_SDEC, 64'h80, ipf_pkg::SIZE_8, 5'b00000, 8'd0,
                           PREC_DEFAULT, 1'b1, 64'h38_32_31_2D, 9'd4));
    stimulus.push_back(row(ipf_pkg::KIND_SDEC, 64'd0, ipf_pkg::SIZE_8, 5'b01000, 8'd0, 9'd0,
                           1'b1, 64'h2B, 9'd1));
    stimulus.push_back(row(ipf_pkg::KIND_SDEC, 64'd0, ipf_pkg::SIZE_8, 5'b00010, 8'd0, 9'd0,
                           1'b1, 64'h20, 9'd1));
    stimulus.push_back(row(ipf_pkg::KIND_SDEC, 64'h5, ipf_pkg::SIZE_32, 5'b01010, 8'd4,
                           PREC_DEFAULT));
    stimulus.push_back(row(ipf_pkg::KIND_SDEC, 64'h8000_0000_0000_0000, ipf_pkg::SIZE_64,
                           5'b00000, 8'd0, PREC_DEFAULT));
    stimulus.push_back(row(ipf_pkg::KIND_SDEC, '1, ipf_pkg::SIZE_16, 5'b00100, 8'd8, 9'd3));
    stimulus.push_back(row(ipf_pkg::KIND_SDEC, 64'h7F, ipf_pkg::SIZE_8, 5'b10100, 8'd6,
                           PREC_DEFAULT));
    stimulus.push_back(row(ipf_pkg::KIND_UDEC, '1, ipf_pkg::SIZE_64, 5'b00000, 8'd0,
                           PREC_DEFAULT));
    stimulus.push_back(row(ipf_pkg::KIND_UDEC, 64'hFFFF_FFFF_FFFF_FF80, ipf_pkg::SIZE_8,
                           5'b01011, 8'd0, PREC_DEFAULT, 1'b1, 64'h38_32_31, 9'd3));
    stimulus.push_back(row(ipf_pkg::KIND_OCT, 64'd8, ipf_pkg::SIZE_8, 5'b00001, 8'd0,
                           PREC_DEFAULT, 1'b1, 64'h30_31_30, 9'd3));
    stimulus.push_back(row(ipf_pkg::KIND_OCT, 64'd8, ipf_pkg::SIZE_8, 5'b00001, 8'd0, 9'd5));
    stimulus.push_back(row(ipf_pkg::KIND_OCT, 64'd0, ipf_pkg::SIZE_8, 5'b00001, 8'd0, 9'd0,
                           1'b1, 64'h30, 9'd1));
    stimulus.push_back(row(ipf_pkg::KIND_HEXL, 64'hABC, ipf_pkg::SIZE_16, 5'b00101, 8'd10,
                           PREC_DEFAULT));
    stimulus.push_back(row(ipf_pkg::KIND_HEXU, '1, ipf_pkg::SIZE_64, 5'b00001, 8'd0,
                           PREC_DEFAULT));
    stimulus.push_back(row(ipf_pkg::KIND_HEXL, 64'd0, ipf_pkg::SIZE_8, 5'b00001, 8'd0,
                           PREC_DEFAULT, 1'b1, 64'h30, 9'd1));
    stimulus.push_back(row(ipf_pkg::KIND_BIN, 64'd5, ipf_pkg::SIZE_8, 5'b00001, 8'd0,
                           PREC_DEFAULT, 1'b1, 64'h31_30_31_21_30, 9'd5));
    stimulus.push_back(row(ipf_pkg::KIND_BIN, '1, ipf_pkg::SIZE_64, 5'b10001, 8'd255,
                           9'd255));
    stimulus.push_back(row(3'd6, 64'h12, ipf_pkg::SIZE_8, 5'b00000, 8'd0, PREC_DEFAULT,
                           1'b1, 64'h38_31, 9'd2));
    stimulus.push_back(row(3'd7, 64'hFF, ipf_pkg::SIZE_8, 5'b00100, 8'd255, 9'd255));
    stimulus.push_back(row(ipf_pkg::KIND_UDEC, 64'd42, ipf_pkg::SIZE_32, 5'b10000, 8'd255,
                           9'h100));
    for (int i = 0; i < NUM_RANDOM; i++) stimulus.push_back(random_req());

    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // The sender works in bursts, usually separated by random gaps.
    while (stimulus.size() > 0) begin
      int burst;
      burst = $urandom_range(1, 12);
      while (burst > 0 && stimulus.size() > 0) begin
        fmt_req_t r;
        r = stimulus.pop_front();
        kind = r.kind; value = r.value; operand_size = r.size;
        {left_align, force_plus, zero_pad, blank_sign, alternate_form} = r.flags;
        field_width = r.width; min_digits = r.prec;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        format_field(r);
        fields_sent++;
        burst--;
        @(negedge clk);
      end
      in_valid = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    in_valid = 1'b0;
    stim_done = 1'b1;
  end

  // The receiver stalls in runs: quiet phases, heavy phases and single blips.
  initial begin
    int mode;
    while (1) begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Output checker and watchdog, both on the rising edge.
  always @(posedge clk) begin
    chunk_t e;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        chunks_seen++;
        if (pending_chunks.size() == 0) begin
          $error("chunk arrived with nothing expected: text %h", text_bytes);
          errors++;
        end else begin
          e = pending_chunks.pop_front();
          if (text_bytes !== e.text) begin
            $error("text_bytes expected %h actual %h", e.text, text_bytes); errors++;
          end
          if (byte_count !== e.count) begin
            $error("byte_count expected %0d actual %0d", e.count, byte_count); errors++;
          end
          if (last_chunk !== e.last) begin
            $error("last_chunk expected %0d actual %0d", e.last, last_chunk); errors++;
          end
          if (field_length !== e.flen) begin
            $error("field_length expected %0d actual %0d", e.flen, field_length); errors++;
          end
        end
      end
    end
  end

  // End of run: drain, wait out the pipeline, then report.
  initial begin
    fork
      begin
        wait (stim_done);
        while (pending_chunks.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (pending_chunks.size() != 0) errors++;
        $display("Formatted %0d fields into %0d chunks across all kinds, sizes and flags.",
                 fields_sent, chunks_seen);
        if (errors == 0) $display("integer_printf_formatter_top: match");
        else $display("integer_printf_formatter_top: mismatch");
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Watchdog expired with %0d chunks outstanding.", pending_chunks.size());
        $display("integer_printf_formatter_top: mismatch");
      end
    join_any
    $finish;
  end

endmodule

### filelist.f
src/ipf_pkg.sv
src/ipf_decode.sv
src/ipf_bcd_stage.sv
src/ipf_digits.sv
src/ipf_chunker.sv
src/integer_printf_formatter_top.sv
src/ipf_checker.sv
bench/tb_integer_printf_formatter_top.sv
